FILE: rtl/trimmed_mean_sample_averager_macros.svh
// Assertion macros for the trimmed-mean sample averager.
// Used by the top level; no other dependencies.
`ifndef TRIMMED_MEAN_SAMPLE_AVERAGER_MACROS_SVH
`define TRIMMED_MEAN_SAMPLE_AVERAGER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define TMSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmsa: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define TMSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmsa: next-cycle check failed");

`endif

FILE: rtl/tmsa_pkg.sv
// Shared constants, types and helpers of the trimmed-mean sample averager.
// No dependencies; used by the interfaces, the shared ALU and the top level.
package tmsa_pkg;

    // Block size and sample range
    localparam int SAMPLES    = 32;
    localparam int SAMPLE_MAX = 4095;
    localparam int SAMPLE_W   = 12;

    // Derived widths
    localparam int SUM_W   = $clog2(SAMPLES * SAMPLE_MAX + 1);
    localparam int COUNT_W = $clog2(SAMPLES + 1);
    localparam int ATT_W   = $clog2(SAMPLES);
    localparam int DIVC_W  = $clog2(SUM_W);

    // Shared ALU operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic             borrow;
        logic [SUM_W-1:0] value;
    } t_alu_res;

    // Clamp a raw reading to the sample ceiling
    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] r;
        r = s;
        if (32'(s) > SAMPLE_MAX) begin
            r = SAMPLE_W'(SAMPLE_MAX);
        end
        return r;
    endfunction

endpackage

FILE: rtl/tmsa_if.sv
// Valid/ready channel interfaces for samples in and averages out.
// Depends on tmsa_pkg.
interface tmsa_in_if
    import tmsa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ok;

    modport source (output valid, output sample, output sample_ok, input ready);
    modport sink   (input valid, input sample, input sample_ok, output ready);
endinterface

interface tmsa_out_if
    import tmsa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

FILE: rtl/tmsa_alu.sv
// Shared add/subtract unit: accumulation, trimming, rounding and divide steps.
// Depends on tmsa_pkg.
module tmsa_alu
    import tmsa_pkg::*;
(
    input  t_alu_op          i_op,
    input  logic [SUM_W-1:0] i_a,
    input  logic [SUM_W-1:0] i_b,
    output t_alu_res         o_res
);

    logic [SUM_W:0] w_full;

    // Add or subtract with one extra bit for carry/borrow
    always_comb begin
        case (i_op)
            ALU_ADD: w_full = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_full = {1'b0, i_a} - {1'b0, i_b};
            default: w_full = '0;
        endcase
        o_res.borrow = w_full[SUM_W];
        o_res.value  = w_full[SUM_W-1:0];
    end

endmodule

FILE: rtl/trimmed_mean_sample_averager.sv
// Top level of the trimmed-mean sample averager: sequencer, block state, output register.
// Depends on tmsa_pkg, tmsa_if, tmsa_alu and trimmed_mean_sample_averager_macros.svh.
//
// Usage:
//   i_in carries one conversion attempt per transaction: a 12-bit sample and
//   a success flag. Every SAMPLES (32) attempts form one block. After the last
//   attempt of a block, o_out delivers one transaction with the rounded mean
//   of the valid samples, the single smallest and largest dropped when more
//   than two were valid, and zero when none was valid.
//   Each attempt is accepted, then accumulated; i_in.ready is low
//   during the accumulate cycle. At block end the shared adder subtracts the
//   smallest and then the largest valid sample (only when more than two were
//   valid), adds half the count for rounding and runs a restoring divide
//   over the SUM_W (17) bits of the sum, then the output register is loaded;
//   with no valid sample it is loaded with zero straight after the trim state.
//   The output register holds the average until o_out.ready takes it; the
//   next block accepts attempts meanwhile. Should a new block finish while
//   the previous average still waits, the sequencer holds until it is taken.
//   Synchronous active-low reset clears the block state and drops any
//   pending average.
`include "trimmed_mean_sample_averager_macros.svh"

module trimmed_mean_sample_averager
    import tmsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmsa_in_if.sink    i_in,
    tmsa_out_if.source o_out
);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ACC      = 3'd1;
    localparam logic [2:0] S_TRIM_MIN = 3'd2;
    localparam logic [2:0] S_TRIM_MAX = 3'd3;
    localparam logic [2:0] S_ROUND    = 3'd4;
    localparam logic [2:0] S_DIV      = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0]          r_state,     n_state;
    logic [SUM_W-1:0]    r_sum,       n_sum;
    logic [SAMPLE_W-1:0] r_min,       n_min;
    logic [SAMPLE_W-1:0] r_max,       n_max;
    logic [COUNT_W-1:0]  r_count,     n_count;
    logic [ATT_W-1:0]    r_attempt,   n_attempt;
    logic [SAMPLE_W-1:0] r_sample,    n_sample;
    logic                r_ok,        n_ok;
    logic [COUNT_W-1:0]  r_rem,       n_rem;
    logic [DIVC_W-1:0]   r_div_cnt,   n_div_cnt;
    logic [SAMPLE_W-1:0] r_avg,       n_avg;
    logic                r_out_valid, n_out_valid;

    t_alu_op          w_op;
    logic [SUM_W-1:0] w_a;
    logic [SUM_W-1:0] w_b;
    t_alu_res         w_res;
    logic [COUNT_W:0] w_shifted;
    logic             w_in_acc;
    logic             w_out_acc;

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.average = r_avg;
    assign w_in_acc      = i_in.valid && (r_state == S_IDLE);
    assign w_out_acc     = r_out_valid && o_out.ready;

    // Partial remainder with the next dividend bit shifted in
    assign w_shifted = {r_rem, r_sum[SUM_W-1]};

    // Steer the shared adder
    always_comb begin
        w_op = ALU_ADD;
        w_a  = r_sum;
        w_b  = '0;
        case (r_state)
            S_ACC: begin
                w_b = SUM_W'(r_sample);
            end
            S_TRIM_MIN: begin
                w_op = ALU_SUB;
                w_b  = SUM_W'(r_min);
            end
            S_TRIM_MAX: begin
                w_op = ALU_SUB;
                w_b  = SUM_W'(r_max);
            end
            S_ROUND: begin
                w_b = SUM_W'(r_count >> 1);
            end
            S_DIV: begin
                w_op = ALU_SUB;
                w_a  = SUM_W'(w_shifted);
                w_b  = SUM_W'(r_count);
            end
            default: begin
                w_op = ALU_ADD;
            end
        endcase
    end

    tmsa_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res)
    );

    // Sequence one attempt, and the trim/round/divide at block end
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_count     = r_count;
        n_attempt   = r_attempt;
        n_sample    = r_sample;
        n_ok        = r_ok;
        n_rem       = r_rem;
        n_div_cnt   = r_div_cnt;
        n_avg       = r_avg;
        n_out_valid = r_out_valid;

        // Drop the pending average once taken
        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sample = sat_sample(i_in.sample);
                    n_ok     = i_in.sample_ok;
                    n_state  = S_ACC;
                end
            end
            S_ACC: begin
                if (r_ok) begin
                    n_sum   = w_res.value;
                    n_count = r_count + COUNT_W'(1);
                    if (r_sample < r_min) begin
                        n_min = r_sample;
                    end
                    if (r_sample > r_max) begin
                        n_max = r_sample;
                    end
                end
                if (r_attempt == ATT_W'(SAMPLES - 1)) begin
                    n_state = S_TRIM_MIN;
                end else begin
                    n_attempt = r_attempt + ATT_W'(1);
                    n_state   = S_IDLE;
                end
            end
            S_TRIM_MIN: begin
                if (r_count == '0) begin
                    n_state = S_OUT;
                end else if (r_count > COUNT_W'(2)) begin
                    n_sum   = w_res.value;
                    n_state = S_TRIM_MAX;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_TRIM_MAX: begin
                n_sum   = w_res.value;
                n_count = r_count - COUNT_W'(2);
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_sum     = w_res.value;
                n_rem     = '0;
                n_div_cnt = DIVC_W'(SUM_W - 1);
                n_state   = S_DIV;
            end
            S_DIV: begin
                // Restoring divide: quotient bits shift into the sum register
                if (!w_res.borrow) begin
                    n_rem = w_res.value[COUNT_W-1:0];
                end else begin
                    n_rem = w_shifted[COUNT_W-1:0];
                end
                n_sum = {r_sum[SUM_W-2:0], !w_res.borrow};
                if (r_div_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_div_cnt = r_div_cnt - DIVC_W'(1);
                end
            end
            S_OUT: begin
                // Hold until the output register is free, then clear the block
                if (!r_out_valid || o_out.ready) begin
                    n_avg       = r_sum[SAMPLE_W-1:0];
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_min       = SAMPLE_W'(SAMPLE_MAX);
                    n_max       = '0;
                    n_count     = '0;
                    n_attempt   = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_min       <= SAMPLE_W'(SAMPLE_MAX);
            r_max       <= '0;
            r_count     <= '0;
            r_attempt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_count     <= n_count;
            r_attempt   <= n_attempt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_ok      <= n_ok;
        r_rem     <= n_rem;
        r_div_cnt <= n_div_cnt;
        r_avg     <= n_avg;
    end

    // Checks
    `TMSA_ASSERT_NEXT(a_accept_then_acc, i_clk, i_rst_n, w_in_acc, r_state == S_ACC)
    `TMSA_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_count)
    `TMSA_ASSERT_NOW(a_count_le_attempts, i_clk, i_rst_n, r_state == S_IDLE,
        r_count <= COUNT_W'(r_attempt))
    `TMSA_ASSERT_NOW(a_min_le_max, i_clk, i_rst_n, (r_state == S_IDLE) && (r_count != '0),
        r_min <= r_max)

endmodule
